>>> src/ctg_pkg.sv
// ----------------------------------------------------------------------------
// ctg_pkg: shared types and constants of the cycloidal trajectory generator.
// Holds the item payload structs, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package ctg_pkg;

  // Input item of one control tick.
  typedef struct packed {
    logic [16:0] tick_period;
    logic        restart;
  } in_item_t;

  // Result item of one control tick.
  typedef struct packed {
    logic signed [21:0] position;
    logic               done_res;
  } out_item_t;

  // Register indexes (word addresses on the configuration port).
  localparam logic [1:0] RegStart = 2'd0;
  localparam logic [1:0] RegDisp  = 2'd1;
  localparam logic [1:0] RegDur   = 2'd2;

  localparam logic [25:0] TimeMax    = 26'h3FFFFFF;
  localparam logic [25:0] DurReset   = 26'd1000000;
  localparam logic [31:0] OneQ30     = 32'h4000_0000;
  localparam logic [16:0] AngleStep  = 17'd102944;
  localparam logic [27:0] InvTwoPi   = 28'd170891318;
  localparam logic signed [22:0] PosLimit = 23'sd2000000;

  // Horner divisors by step are split as 2^e * o. The quotient of a dividend
  // below 2^32 is ((a >> e) * m) >> s with m = ceil(2^s / o), which is exact
  // because (a >> e) stays below 2^31 and s = 31 + ceil(log2(o)).

  // Pre-shift e of each Horner divisor (110, 72, 42, 20, 6).
  function automatic logic [1:0] horner_shift(input logic [2:0] idx);
    logic [1:0] e;
    e = 2'd1;
    unique case (idx)
      3'd0: e = 2'd1;
      3'd1: e = 2'd3;
      3'd2: e = 2'd1;
      3'd3: e = 2'd2;
      default: e = 2'd1;
    endcase
    return e;
  endfunction

  // Reciprocal m of the odd part of each Horner divisor (55, 9, 21, 5, 3).
  function automatic logic [31:0] horner_recip(input logic [2:0] idx);
    logic [31:0] m;
    m = 32'd2863311531;
    unique case (idx)
      3'd0: m = 32'd2498890064;
      3'd1: m = 32'd3817748708;
      3'd2: m = 32'd3272356036;
      3'd3: m = 32'd3435973837;
      default: m = 32'd2863311531;
    endcase
    return m;
  endfunction

  // Post-shift s of each Horner reciprocal product.
  function automatic logic [5:0] horner_post(input logic [2:0] idx);
    logic [5:0] s;
    s = 6'd33;
    unique case (idx)
      3'd0: s = 6'd37;
      3'd1: s = 6'd35;
      3'd2: s = 6'd36;
      3'd3: s = 6'd34;
      default: s = 6'd33;
    endcase
    return s;
  endfunction

endpackage

>>> src/cycloidal_trajectory_generator_unit.sv
// ----------------------------------------------------------------------------
// cycloidal_trajectory_generator_unit: one axis of a timed cycloidal move.
// A small sequencer drives one shared shift-subtract divider and one shared
// multiplier to form u, the sine by Horner iteration and the position.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | in_item_t (tick_period, restart)
// out     | output    | out_valid_o/out_ready_i | out_item_t (position, done_res)
// cfg     | input     | APB psel/penable      | start, displacement, duration
//
// When u < 1, a taken item goes through the divide of u, the angle and its
// square, the five Horner steps and the finishing steps before its result is
// presented. When u is clamped the divide is skipped.
// Each Horner step divides by a small constant through a reciprocal multiply.
// Reset clears the time, the done state and the registers to their reset
// values. A result waits in the output register; the next item is taken once
// the previous result has been handed over.
// ----------------------------------------------------------------------------
module cycloidal_trajectory_generator_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ctg_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ctg_pkg::out_item_t   out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StDivU  = 9'b000000010,
    StSq    = 9'b000000100,
    StHMul  = 9'b000001000,
    StHDiv  = 9'b000010000,
    StSin   = 9'b000100000,
    StTerm  = 9'b001000000,
    StOff   = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [21:0] start_q, disp_q;
  logic [25:0] dur_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      disp_q  <= '0;
      dur_q   <= ctg_pkg::DurReset;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        ctg_pkg::RegStart: start_q <= pwdata[21:0];
        ctg_pkg::RegDisp:  disp_q  <= pwdata[21:0];
        ctg_pkg::RegDur:   dur_q   <= pwdata[25:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      ctg_pkg::RegStart: prdata = {{10{start_q[21]}}, start_q};
      ctg_pkg::RegDisp:  prdata = {{10{disp_q[21]}}, disp_q};
      ctg_pkg::RegDur:   prdata = {6'd0, dur_q};
      default:           prdata = '0;
    endcase
  end

  // Motion state and working registers.
  logic [25:0] time_q;
  logic        fin_q;
  logic [16:0] u_q;
  logic [31:0] x_q, x2_q, t_q;    // Q30 values
  logic [30:0] f_q;               // clamped profile fraction in Q30
  logic [62:0] prod_q;            // shared multiplier output register
  logic [42:0] rem_q;             // divider remainder / dividend
  logic [42:0] quo_q;             // divider dividend bits and quotient
  logic [5:0]  cnt_q;
  logic [2:0]  step_q;
  logic        neg_q;
  ctg_pkg::out_item_t out_q;
  logic        out_valid_q;

  // Shared multiplier operands (32 x 32, registered into prod_q).
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Shared restoring divider step for u.
  logic [43:0] trial;
  logic [42:0] rem_sh;
  assign rem_sh  = {rem_q[41:0], quo_q[42]};
  assign trial   = {1'b0, rem_sh} - {18'd0, dur_q};

  // Time update for an accepted item.
  logic [26:0] tsum;
  logic [25:0] tbase;
  logic [25:0] tnew;
  logic        clamp;
  assign tbase = in_item_i.restart ? 26'd0 : time_q;
  assign tsum  = {1'b0, tbase} + {10'd0, in_item_i.tick_period};
  assign tnew  = tsum[26] ? ctg_pkg::TimeMax : tsum[25:0];
  assign clamp = (dur_q == '0) || (tnew >= dur_q);

  // Horner quotient from the reciprocal product.
  logic [31:0] h_quot;
  assign h_quot = 32'(prod_q >> ctg_pkg::horner_post(step_q));

  // Phase folding.
  logic [1:0]  quad;
  logic [14:0] r_fold;
  assign quad   = u_q[15:14];
  assign r_fold = quad[0] ? (15'd16384 - {1'b0, u_q[13:0]}) : {1'b0, u_q[13:0]};

  // Result forming from prod_q in StOut.
  logic [31:0] sin_mag;
  logic signed [32:0] f_s;
  logic [30:0] f_c;
  logic [21:0] disp_mag;
  logic [53:0] off_mag;
  logic [23:0] rq;
  logic signed [24:0] pos_s;
  logic signed [21:0] pos_sat;

  always_comb begin
    sin_mag = (prod_q[62:30] > {1'b0, ctg_pkg::OneQ30}) ? ctg_pkg::OneQ30
                                                        : prod_q[61:30];
  end

  // The fraction is never negative, so the offset takes the sign of the
  // displacement and its magnitude comes from the unsigned product.
  assign disp_mag = disp_q[21] ? (22'd0 - disp_q) : disp_q;
  assign off_mag  = prod_q[53:0];
  assign rq       = 24'((off_mag + (54'd1 << 29)) >> 30);
  assign pos_s    = $signed({{3{start_q[21]}}, start_q})
                  + (disp_q[21] ? -$signed({1'b0, rq}) : $signed({1'b0, rq}));
  always_comb begin
    if (pos_s > 25'(ctg_pkg::PosLimit))       pos_sat = 22'(ctg_pkg::PosLimit);
    else if (pos_s < -25'(ctg_pkg::PosLimit)) pos_sat = 22'(-ctg_pkg::PosLimit);
    else                                      pos_sat = pos_s[21:0];
  end

  // Sine term in Q30 from the previous product, combined with u.
  assign f_s = $signed({2'b0, u_q, 14'd0})
             + (neg_q ? $signed({1'b0, prod_q[61:30]}) : -$signed({1'b0, prod_q[61:30]}));
  always_comb begin
    if (f_s < 0)                                   f_c = '0;
    else if (f_s > $signed({1'b0, ctg_pkg::OneQ30})) f_c = 31'(ctg_pkg::OneQ30);
    else                                           f_c = f_s[30:0];
  end

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StSq: begin
        if (cnt_q == 6'd3) begin
          mul_a = x_q;
          mul_b = x_q;
        end else begin
          mul_a = {17'd0, r_fold};
          mul_b = {15'd0, ctg_pkg::AngleStep};
        end
      end
      StHMul: begin mul_a = x2_q; mul_b = t_q; end
      StHDiv: begin mul_a = quo_q[31:0]; mul_b = ctg_pkg::horner_recip(step_q); end
      StSin:  begin mul_a = x_q;  mul_b = t_q; end
      StTerm: begin mul_a = sin_mag; mul_b = {4'd0, ctg_pkg::InvTwoPi}; end
      StOff:  begin mul_a = {1'b0, f_q}; mul_b = {10'd0, disp_mag}; end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      time_q      <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      step_q      <= '0;
      u_q         <= '0;
      x_q         <= '0;
      x2_q        <= '0;
      t_q         <= '0;
      f_q         <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      neg_q       <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            time_q <= tnew;
            fin_q  <= clamp ? 1'b1 : (in_item_i.restart ? 1'b0 : fin_q);
            if (clamp) begin
              quo_q   <= 43'h10000;
              cnt_q   <= '0;
              state_q <= StSq;
            end else begin
              rem_q   <= '0;
              quo_q   <= {1'b0, tnew, 16'd0};
              cnt_q   <= 6'd43;
              state_q <= StDivU;
            end
          end
        end
        StDivU: begin
          if (trial[43]) begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[41:0], 1'b0};
          end else begin
            rem_q <= trial[42:0];
            quo_q <= {quo_q[41:0], 1'b1};
          end
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            state_q <= StSq;
            cnt_q   <= '0;
          end
        end
        StSq: begin
          // Takes u, then forms x = r * step and x*x in turn.
          if (cnt_q == '0) begin
            u_q   <= quo_q[16:0];
            cnt_q <= 6'd1;
          end else if (cnt_q == 6'd1) begin
            cnt_q <= 6'd2;
          end else if (cnt_q == 6'd2) begin
            x_q   <= prod_q[31:0];
            cnt_q <= 6'd3;
          end else if (cnt_q == 6'd3) begin
            cnt_q <= 6'd4;
          end else begin
            x2_q    <= prod_q[61:30];
            t_q     <= ctg_pkg::OneQ30;
            step_q  <= '0;
            cnt_q   <= '0;
            state_q <= StHMul;
          end
        end
        StHMul: begin
          if (cnt_q == '0) cnt_q <= 6'd1;
          else begin
            quo_q   <= {11'd0, prod_q[61:30] >> ctg_pkg::horner_shift(step_q)};
            cnt_q   <= '0;
            state_q <= StHDiv;
          end
        end
        StHDiv: begin
          if (cnt_q == '0) cnt_q <= 6'd1;
          else begin
            if (h_quot >= ctg_pkg::OneQ30) t_q <= '0;
            else t_q <= ctg_pkg::OneQ30 - h_quot;
            cnt_q <= '0;
            if (step_q == 3'd4) state_q <= StSin;
            else begin
              step_q  <= step_q + 3'd1;
              state_q <= StHMul;
            end
          end
        end
        StSin: begin
          if (cnt_q == '0) cnt_q <= 6'd1;
          else begin
            cnt_q   <= '0;
            state_q <= StTerm;
          end
        end
        StTerm: begin
          if (cnt_q == '0) begin
            neg_q <= quad[1] && (sin_mag != '0);
            cnt_q <= 6'd1;
          end else begin
            f_q     <= f_c;
            cnt_q   <= '0;
            state_q <= StOff;
          end
        end
        StOff: begin
          if (cnt_q == '0) cnt_q <= 6'd1;
          else begin
            cnt_q   <= '0;
            state_q <= StOut;
          end
        end
        StOut: begin
          out_q.position <= pos_sat;
          out_q.done_res <= fin_q;
          out_valid_q    <= 1'b1;
          state_q        <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Shared multiplier output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else begin
      prod_q <= mul_p[62:0];
    end
  end

`ifndef SYNTH
  // No new item is taken while a result is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("item taken over pending result");
  // A result appears only at the end of the sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StOut)) else $error("stray result");
  // The sequencer is one-hot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
`endif

endmodule

>>> dv/cycloidal_trajectory_generator_unit_test.sv
// ----------------------------------------------------------------------------
// Cycloidal trajectory generator testbench
// Drives control ticks through the valid/ready channel and checks each
// commanded position and done flag against a bit-exact fixed-point model of
// the cycloidal profile. Registers are rewritten between phases through the
// APB port, with random gaps on both channels.
// ----------------------------------------------------------------------------
module cycloidal_trajectory_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Profile model with its own copy of the time state and registers.
  class profile_scoreboard;
    logic [21:0] start_pos;
    logic [21:0] disp;
    logic [25:0] dur;
    logic [25:0] elapsed;
    bit          finished;
    ctg_pkg::out_item_t pending[$];
    int          errors;

    function void reset_state();
      start_pos = '0;
      disp      = '0;
      dur       = 26'd1000000;
      elapsed   = '0;
      finished  = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        ctg_pkg::RegStart: start_pos = val[21:0];
        ctg_pkg::RegDisp:  disp      = val[21:0];
        ctg_pkg::RegDur:   dur       = val[25:0];
        default: ;
      endcase
    endfunction

    // Absolute sine of phase p (one turn = 65536) in Q30.
    function longint unsigned sine_abs(longint unsigned p, output bit neg);
      longint unsigned q, r, x, x2, t, d, s;
      longint unsigned dv[5];
      dv = '{110, 72, 42, 20, 6};
      q = (p >> 14) & 3;
      r = p & 16'h3FFF;
      if (q[0]) r = 16384 - r;
      x  = r * 102944;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int i = 0; i < 5; i++) begin
        d = ((x2 * t) >> 30) / dv[i];
        t = (d >= (64'd1 << 30)) ? 0 : (64'd1 << 30) - d;
      end
      s = (x * t) >> 30;
      if (s > (64'd1 << 30)) s = 64'd1 << 30;
      neg = (q >= 2) && (s != 0);
      return s;
    endfunction

    // Notes an accepted tick and queues the position it should produce.
    function void note_tick(ctg_pkg::in_item_t it);
      longint unsigned tsum, u, mag, m, rq;
      longint f, prod, off, pos;
      bit neg;
      ctg_pkg::out_item_t res;
      if (it.restart) begin
        elapsed  = '0;
        finished = 0;
      end
      tsum = longint'(elapsed) + it.tick_period;
      if (tsum > 64'h3FFFFFF) tsum = 64'h3FFFFFF;
      elapsed = tsum[25:0];
      if (dur == 0 || elapsed >= dur) begin
        u = 65536;
        finished = 1;
      end else begin
        u = (longint'(elapsed) << 16) / dur;
        if (u > 65536) u = 65536;
      end
      mag = sine_abs(u & 16'hFFFF, neg);
      m   = (mag * 170891318) >> 30;
      f   = longint'(u << 14);
      f   = neg ? f + longint'(m) : f - longint'(m);
      if (f < 0) f = 0;
      if (f > (64'sd1 <<< 30)) f = 64'sd1 <<< 30;
      prod = longint'($signed(disp)) * f;
      mag  = (prod < 0) ? longint'(-prod) : prod;
      rq   = (mag + (64'd1 << 29)) >> 30;
      off  = (prod < 0) ? -longint'(rq) : longint'(rq);
      pos  = longint'($signed(start_pos)) + off;
      if (pos > 2000000) pos = 2000000;
      if (pos < -2000000) pos = -2000000;
      res.position = pos[21:0];
      res.done_res = finished;
      pending.push_back(res);
    endfunction

    function void check_result(ctg_pkg::out_item_t got);
      ctg_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result pos=%0d done=%0d", $time,
                 got.position, got.done_res);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.position !== want.position) begin
        $display("%0t: position expected %0d actual %0d", $time,
                 want.position, got.position);
        errors++;
      end
      if (got.done_res !== want.done_res) begin
        $display("%0t: done expected %0d actual %0d", $time,
                 want.done_res, got.done_res);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  ctg_pkg::in_item_t  in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  ctg_pkg::out_item_t out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  profile_scoreboard sb;
  int  stall_cycles;
  localparam int StallLimit = 20000;

  cycloidal_trajectory_generator_unit i_dut (.*);

  // Clock.
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Random gap length: mostly short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  task automatic send_tick(logic [16:0] period, bit rst_time);
    ctg_pkg::in_item_t it;
    int g;
    g = gap_len();
    repeat (g) @(negedge clk_i);
    it.tick_period = period;
    it.restart     = rst_time;
    @(negedge clk_i);
    in_valid_i <= 1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_tick(it);
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  // Waits until every queued result has come, then for the tail latency.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Random tick period, biased toward steps that cross the move in few items.
  function automatic logic [16:0] rand_period(logic [25:0] d);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 17'd0;
    if (r < 10) return 17'd100000;
    if (r < 15) return 17'h1FFFF;
    if (d < 400) return 17'($urandom_range(0, 200));
    if (d / 20 < 100000) return 17'($urandom_range(0, d / 20 + 1));
    return 17'($urandom_range(0, 100000));
  endfunction

  // One phase: registers set, then a run of ticks with occasional restarts.
  task automatic run_phase(logic [31:0] s, logic [31:0] dsp, logic [31:0] d, int n);
    write_reg(ctg_pkg::RegStart, s);
    write_reg(ctg_pkg::RegDisp, dsp);
    write_reg(ctg_pkg::RegDur, d);
    send_tick(17'd0, 1);
    for (int i = 0; i < n; i++)
      send_tick(rand_period(sb.dur), ($urandom_range(0, 29) == 0));
    drain();
  endtask

  // Result side: random back-pressure and checking.
  initial begin
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(20, 120)) @(negedge clk_i);
        out_ready_i <= 1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) < 15) ? 1'b0 : 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  // Watchdog on cycles without any accepted item, result or register access.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || psel)
      stall_cycles <= 0;
    else if (sb.pending.size() != 0 || in_valid_i)
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    logic [31:0] s, dsp, d;
    sb = new();
    sb.reset_state();
    in_valid_i = 0;
    in_item_i  = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Directed: reset values, extremes of fields, saturation, zero duration.
    send_tick(17'd0, 0);
    send_tick(17'(250000), 0);
    send_tick(17'h1FFFF, 0);
    send_tick(17'd100000, 1);
    drain();
    write_reg(ctg_pkg::RegStart, 32'(-2000000));
    write_reg(ctg_pkg::RegDisp, 32'd2000000);
    write_reg(ctg_pkg::RegDur, 32'd1000);
    send_tick(17'd250, 1);
    send_tick(17'd250, 0);
    send_tick(17'd250, 0);
    send_tick(17'd250, 0);
    send_tick(17'd300, 0);   // overshoot clamps u to one
    send_tick(17'd1, 0);     // ticks after done
    send_tick(17'd0, 1);
    drain();
    write_reg(ctg_pkg::RegStart, 32'h001FFFFF);  // out-of-range start
    write_reg(ctg_pkg::RegDisp, 32'h00200000);
    write_reg(ctg_pkg::RegDur, 32'd0);            // zero duration: instant move
    send_tick(17'd0, 0);
    send_tick(17'd5, 1);
    drain();
    write_reg(ctg_pkg::RegDur, 32'h03FFFFFF);
    for (int i = 0; i < 6; i++) send_tick(17'h1FFFF, 0);
    drain();
    write_reg(ctg_pkg::RegDur, 32'd1);
    send_tick(17'd0, 1);
    send_tick(17'd1, 0);
    drain();

    // Random phases, including extreme registers.
    for (int ph = 0; ph < 14; ph++) begin
      s   = 32'($signed($urandom_range(0, 4000000)) - 2000000);
      dsp = 32'($signed($urandom_range(0, 4000000)) - 2000000);
      case ($urandom_range(0, 4))
        0: d = $urandom_range(1, 300);
        1: d = $urandom_range(300, 100000);
        2: d = $urandom_range(100000, 3000000);
        3: d = 60000000;
        default: d = $urandom_range(0, 20);
      endcase
      if (ph == 0) begin s = 32'd2000000; dsp = 32'(-2000000); end
      if (ph == 1) begin s = 32'h001FFFFF; dsp = 32'h001FFFFF; end
      if (ph == 2) s = $urandom;
      run_phase(s, dsp, d, 120);
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
